FILE: rtl/arfc_pkg.sv
// Shared types, constants and fixed filter coefficients for the resampling filter chain.
`default_nettype none
package arfc_pkg;

  localparam int OVERSAMPLE     = 4;
  localparam int OUT_RATE_HZ    = 44100;
  localparam int COEF_FRAC_BITS = 30;

  localparam int PHASE_W = $clog2(OVERSAMPLE + 1);
  localparam int COEF_W  = 32;
  localparam int SAMP_W  = 32;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 33;
  localparam int DLY_W   = 40;
  localparam int RND_W   = 2 * COEF_W - COEF_FRAC_BITS;
  localparam int QUO_W   = 28;
  localparam int DIV_W   = 61;
  localparam int DCNT_W  = $clog2(QUO_W);

  localparam logic [31:0] STEP_MIN   = 32'd65536;
  localparam logic [31:0] STEP_RESET = 32'd1329880;

  // Configuration register indexes.
  localparam logic [1:0] REG_LED    = 2'd0;
  localparam logic [1:0] REG_BYPASS = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;

  // Operation indexes of the per-lane filter program.
  localparam logic [3:0] OP_RC   = 4'd0;
  localparam logic [3:0] OP_LED  = 4'd1;
  localparam logic [3:0] OP_AA0  = 4'd6;
  localparam logic [3:0] OP_AA1  = 4'd11;
  localparam logic [3:0] OP_LAST = 4'd15;

  typedef enum logic [2:0] {
    KIND_RC, KIND_B0, KIND_B1, KIND_A1, KIND_B2, KIND_A2
  } op_kind_t;

  typedef struct packed {
    logic signed [11:0] left_sample;
    logic signed [11:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_pcm;
    logic signed [15:0] right_pcm;
    logic               left_clipped;
    logic               right_clipped;
    logic        [15:0] peak_level;
    logic        [31:0] clip_total;
    logic        [31:0] frame_total;
  } out_item_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [SAMP_W-1:0] y;
  } lane_status_t;

  typedef struct packed {
    logic signed [63:0] b0;
    logic signed [63:0] b1;
    logic signed [63:0] b2;
    logic signed [63:0] a1;
    logic signed [63:0] a2;
  } lp_coef_t;

  // Coefficient design, evaluated at elaboration only.
  localparam int          WP        = 30;
  localparam longint      WONE      = 64'sd1 <<< WP;
  localparam longint unsigned TWO_PI_W = 64'd6746518852;
  localparam longint unsigned FS    = 64'(OUT_RATE_HZ) * 64'(OVERSAMPLE);
  localparam longint      Q_LED     = 64'sd759250125;
  localparam longint      Q_AA0     = 64'sd580894327;
  localparam longint      Q_AA1     = 64'sd1403380564;

  // Restoring long division for the coefficient design routines.
  function automatic longint unsigned udiv_c(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned umulw(longint unsigned a, longint unsigned b);
    longint unsigned hi;
    longint unsigned lo;
    hi = b >> 15;
    lo = b & 64'h7FFF;
    return (a * hi + ((a * lo) >> 15)) >> 15;
  endfunction

  function automatic longint cos_w(longint unsigned w);
    longint unsigned w2;
    longint unsigned tc;
    longint unsigned dv;
    longint          sc;
    w2 = umulw(w, w);
    tc = 64'(WONE);
    sc = WONE;
    for (int k = 1; k <= 16; k++) begin
      dv = 64'(2 * k - 1) * 64'(2 * k);
      tc = udiv_c(umulw(tc, w2), dv);
      if (k % 2 == 1) sc = sc - longint'(tc);
      else sc = sc + longint'(tc);
    end
    return sc;
  endfunction

  function automatic longint sin_w(longint unsigned w);
    longint unsigned w2;
    longint unsigned ts;
    longint unsigned dv;
    longint          ss;
    w2 = umulw(w, w);
    ts = w;
    ss = longint'(w);
    for (int k = 1; k <= 16; k++) begin
      dv = 64'(2 * k) * 64'(2 * k + 1);
      ts = udiv_c(umulw(ts, w2), dv);
      if (k % 2 == 1) ss = ss - longint'(ts);
      else ss = ss + longint'(ts);
    end
    return ss;
  endfunction

  function automatic longint exp_neg(longint unsigned x);
    longint unsigned t;
    longint          s;
    t = 64'(WONE);
    s = WONE;
    for (int k = 1; k <= 24; k++) begin
      t = udiv_c(umulw(t, x), 64'(k));
      if (k % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    if (s > WONE) s = WONE;
    return s;
  endfunction

  function automatic longint sdivw(longint num, longint den);
    longint unsigned m;
    longint unsigned q;
    m = (num < 0) ? longint'(-num) : longint'(num);
    q = udiv_c(m << WP, longint'(den));
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint to_coef(longint w);
    longint half;
    half = (WP > COEF_FRAC_BITS) ? (64'sd1 <<< (WP - COEF_FRAC_BITS - 1)) : 64'sd0;
    return (w + half) >>> (WP - COEF_FRAC_BITS);
  endfunction

  function automatic lp_coef_t design_lowpass(longint unsigned w, longint q);
    lp_coef_t cf;
    longint   c;
    longint   s;
    longint   alpha;
    longint   a0;
    longint   omc;
    c     = cos_w(w);
    s     = sin_w(w);
    alpha = sdivw(s, 2 * q);
    a0    = WONE + alpha;
    if (a0 < 1) a0 = 1;
    omc   = WONE - c;
    cf.b1 = to_coef(sdivw(omc, a0));
    cf.b0 = to_coef(sdivw(omc, 2 * a0));
    cf.b2 = cf.b0;
    cf.a1 = to_coef(-sdivw(2 * c, a0));
    cf.a2 = to_coef(sdivw(WONE - alpha, a0));
    return cf;
  endfunction

  localparam longint unsigned W_AA  = TWO_PI_W * 64'd45 * 64'(OUT_RATE_HZ) / (64'd100 * FS);
  localparam longint unsigned W_LED = TWO_PI_W * 64'd3275 / FS;
  localparam longint unsigned W_RC  = TWO_PI_W * 64'd4421 / FS;
  localparam longint   RC_K   = to_coef(WONE - exp_neg(W_RC));
  localparam lp_coef_t LED_CF = design_lowpass(W_LED, Q_LED);
  localparam lp_coef_t AA0_CF = design_lowpass(W_AA, Q_AA0);
  localparam lp_coef_t AA1_CF = design_lowpass(W_AA, Q_AA1);

  function automatic logic signed [COEF_W-1:0] coef_of(logic [3:0] op);
    logic signed [63:0] c;
    case (op)
      OP_RC:          c = RC_K;
      OP_LED:         c = LED_CF.b0;
      OP_LED + 4'd1:  c = LED_CF.b1;
      OP_LED + 4'd2:  c = LED_CF.a1;
      OP_LED + 4'd3:  c = LED_CF.b2;
      OP_LED + 4'd4:  c = LED_CF.a2;
      OP_AA0:         c = AA0_CF.b0;
      OP_AA0 + 4'd1:  c = AA0_CF.b1;
      OP_AA0 + 4'd2:  c = AA0_CF.a1;
      OP_AA0 + 4'd3:  c = AA0_CF.b2;
      OP_AA0 + 4'd4:  c = AA0_CF.a2;
      OP_AA1:         c = AA1_CF.b0;
      OP_AA1 + 4'd1:  c = AA1_CF.b1;
      OP_AA1 + 4'd2:  c = AA1_CF.a1;
      OP_AA1 + 4'd3:  c = AA1_CF.b2;
      default:        c = AA1_CF.a2;
    endcase
    return c[COEF_W-1:0];
  endfunction

  function automatic op_kind_t op_kind(logic [3:0] op);
    op_kind_t k;
    case (op) inside
      OP_RC:                                          k = KIND_RC;
      OP_LED, OP_AA0, OP_AA1:                         k = KIND_B0;
      OP_LED + 4'd1, OP_AA0 + 4'd1, OP_AA1 + 4'd1:    k = KIND_B1;
      OP_LED + 4'd2, OP_AA0 + 4'd2, OP_AA1 + 4'd2:    k = KIND_A1;
      OP_LED + 4'd3, OP_AA0 + 4'd3, OP_AA1 + 4'd3:    k = KIND_B2;
      default:                                        k = KIND_A2;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] op_stage(logic [3:0] op);
    if (op < OP_AA0) return 2'd0;
    if (op < OP_AA1) return 2'd1;
    return 2'd2;
  endfunction

  function automatic logic signed [SAMP_W-1:0] sat32(logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(64'sd2147483647)) return 32'sh7FFFFFFF;
    if (v < -SUM_W'(64'sd2147483648)) return 32'sh80000000;
    return v[SAMP_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/arfc_lane.sv
// One channel lane: averaging divider followed by the RC, LED and anti-alias filter program.
`default_nettype none
module arfc_lane
  import arfc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] sum,
  input  wire logic        [CNT_W-1:0] n,
  input  wire logic                    byp,
  input  wire logic                    led_on,
  input  wire logic                    ack,
  output lane_status_t                 status
);

  typedef enum logic [4:0] {
    LS_IDLE = 5'b00001,
    LS_DIV  = 5'b00010,
    LS_MUL  = 5'b00100,
    LS_ACC  = 5'b01000,
    LS_DONE = 5'b10000
  } lane_state_t;

  lane_state_t              state_r;
  logic [DIV_W-1:0]         rem_r;
  logic [DIV_W-1:0]         den_r;
  logic [QUO_W-1:0]         q_r;
  logic [DCNT_W-1:0]        cnt_r;
  logic                     neg_r;
  logic [3:0]               op_r;
  logic signed [SAMP_W-1:0] x_r;
  logic signed [SAMP_W-1:0] y_r;
  logic signed [SAMP_W-1:0] lvl_r;
  logic signed [RND_W-1:0]  acc_r;
  logic signed [63:0]       p_r;
  logic signed [DLY_W-1:0]  z0_r [3];
  logic signed [DLY_W-1:0]  z1_r [3];

  logic [SUM_W-1:0]         mag;
  logic                     ge;
  logic [QUO_W-1:0]         q_nxt;
  op_kind_t                 kind;
  logic [1:0]               st;
  logic signed [COEF_W-1:0] coef;
  logic signed [SAMP_W-1:0] d;
  logic signed [SAMP_W-1:0] operand;
  logic signed [63:0]       prod;
  logic signed [63:0]       rnd_full;
  logic signed [RND_W-1:0]  r;
  logic signed [SAMP_W-1:0] lvl_nxt;
  logic signed [SAMP_W-1:0] y_nxt;
  logic signed [DLY_W:0]    z0_sum;
  logic signed [DLY_W:0]    z1_sum;

  always_comb begin
    mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    ge       = rem_r >= den_r;
    q_nxt    = {q_r[QUO_W-2:0], ge};
    kind     = op_kind(op_r);
    st       = op_stage(op_r);
    coef     = coef_of(op_r);
    d        = sat32(SUM_W'(x_r) - SUM_W'(lvl_r));
    case (kind)
      KIND_RC:          operand = d;
      KIND_A1, KIND_A2: operand = y_r;
      default:          operand = x_r;
    endcase
    prod     = 64'(operand) * 64'(coef);
    rnd_full = p_r + (64'sd1 <<< (COEF_FRAC_BITS - 1));
    r        = rnd_full[63:COEF_FRAC_BITS];
    lvl_nxt  = sat32(SUM_W'(lvl_r) + SUM_W'(r));
    y_nxt    = sat32(SUM_W'(r) + SUM_W'(z0_r[st]));
    z0_sum   = (DLY_W+1)'(acc_r) - (DLY_W+1)'(r) + (DLY_W+1)'(z1_r[st]);
    z1_sum   = (DLY_W+1)'(acc_r) - (DLY_W+1)'(r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LS_IDLE;
      lvl_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        z0_r[i] <= '0;
        z1_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        LS_IDLE: begin
          if (start) begin
            neg_r   <= sum[SUM_W-1];
            rem_r   <= {mag[DIV_W-17:0], 16'b0};
            den_r   <= {1'b0, n, 27'b0};
            q_r     <= '0;
            cnt_r   <= DCNT_W'(QUO_W - 1);
            state_r <= LS_DIV;
          end
        end
        LS_DIV: begin
          if (ge) rem_r <= rem_r - den_r;
          q_r   <= q_nxt;
          den_r <= den_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            x_r     <= neg_r ? -SAMP_W'(q_nxt) : SAMP_W'(q_nxt);
            op_r    <= byp ? OP_AA0 : OP_RC;
            state_r <= LS_MUL;
          end
        end
        LS_MUL: begin
          p_r     <= prod;
          state_r <= LS_ACC;
        end
        LS_ACC: begin
          state_r <= (kind == KIND_A2 && op_r == OP_LAST) ? LS_DONE : LS_MUL;
          op_r    <= (kind == KIND_RC) ? (led_on ? OP_LED : OP_AA0) : op_r + 4'd1;
          case (kind)
            KIND_RC: begin
              lvl_r <= lvl_nxt;
              x_r   <= lvl_nxt;
            end
            KIND_B0: y_r <= y_nxt;
            KIND_B1: acc_r <= r;
            KIND_A1: z0_r[st] <= z0_sum[DLY_W-1:0];
            KIND_B2: acc_r <= r;
            default: begin
              z1_r[st] <= z1_sum[DLY_W-1:0];
              x_r      <= y_r;
            end
          endcase
        end
        LS_DONE: begin
          if (ack) state_r <= LS_IDLE;
        end
        default: state_r <= LS_IDLE;
      endcase
    end
  end

  assign status.busy = (state_r != LS_IDLE);
  assign status.done = (state_r == LS_DONE);
  assign status.y    = x_r;

endmodule
`default_nettype wire

FILE: rtl/arfc_merge.sv
// Merging stage: decimation, scaling, rounding, clip and peak tracking, output register.
`default_nettype none
module arfc_merge
  import arfc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire lane_status_t st_l,
  input  wire lane_status_t st_r,
  input  wire logic         out_stall,
  output logic              ack,
  output logic              out_valid,
  output out_item_t         out_data
);

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               clip;
  } pcm_t;

  logic [PHASE_W-1:0] phase_r;
  logic [15:0]        peak_r;
  logic [31:0]        clip_r;
  logic [31:0]        frame_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic signed [35:0] sl;
  logic signed [35:0] sr;
  logic [35:0]        abs_l;
  logic [35:0]        abs_r;
  logic [35:0]        mag;
  logic [15:0]        ipart;
  logic [15:0]        peak_nxt;
  pcm_t               pl;
  pcm_t               pr;
  logic [32:0]        clip_sum;
  logic [31:0]        clip_nxt;
  logic [31:0]        frame_nxt;
  logic               emit;

  // Signed Q20.16 to integer with ties to even, then saturate to 16 bits.
  function automatic pcm_t to_pcm(logic signed [35:0] s);
    pcm_t               res;
    logic signed [19:0] fl;
    logic [15:0]        frac;
    logic               inc;
    logic signed [20:0] ip;
    fl   = s[35:16];
    frac = s[15:0];
    inc  = (frac > 16'h8000) || (frac == 16'h8000 && fl[0]);
    ip   = 21'(fl) + 21'(inc);
    res.clip = 1'b0;
    res.pcm  = ip[15:0];
    if (ip > 21'sd32767) begin
      res.pcm  = 16'sh7FFF;
      res.clip = 1'b1;
    end else if (ip < -21'sd32768) begin
      res.pcm  = 16'sh8000;
      res.clip = 1'b1;
    end
    return res;
  endfunction

  always_comb begin
    sl        = 36'(st_l.y) <<< 4;
    sr        = 36'(st_r.y) <<< 4;
    abs_l     = sl[35] ? 36'(-sl) : 36'(sl);
    abs_r     = sr[35] ? 36'(-sr) : 36'(sr);
    mag       = (abs_l > abs_r) ? abs_l : abs_r;
    ipart     = (mag[35:32] != '0) ? 16'hFFFF : mag[31:16];
    peak_nxt  = (ipart > peak_r) ? ipart : peak_r;
    pl        = to_pcm(sl);
    pr        = to_pcm(sr);
    clip_sum  = 33'(clip_r) + 33'(pl.clip) + 33'(pr.clip);
    clip_nxt  = clip_sum[32] ? 32'hFFFFFFFF : clip_sum[31:0];
    frame_nxt = (frame_r == 32'hFFFFFFFF) ? frame_r : frame_r + 32'd1;
    emit      = (phase_r == PHASE_W'(OVERSAMPLE - 1));
    ack       = st_l.done && st_r.done && (!emit || !out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      peak_r      <= '0;
      clip_r      <= '0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ack && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ack) begin
        phase_r <= emit ? '0 : phase_r + 1'b1;
        if (emit) begin
          peak_r              <= peak_nxt;
          clip_r              <= clip_nxt;
          frame_r             <= frame_nxt;
          out_r.left_pcm      <= pl.pcm;
          out_r.right_pcm     <= pr.pcm;
          out_r.left_clipped  <= pl.clip;
          out_r.right_clipped <= pr.clip;
          out_r.peak_level    <= peak_nxt;
          out_r.clip_total    <= clip_nxt;
          out_r.frame_total   <= frame_nxt;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: rtl/audio_resample_filter_chain.sv
// Top level: integrator, configuration registers, two channel lanes and the merging stage.
//
//   channel | ports                         | direction | moves
//   --------+-------------------------------+-----------+------------------------------
//   in      | in_valid, in_stall, in_data   | in        | one stereo DAC code pair
//   out     | out_valid, out_stall, out_data| out       | one PCM frame with statistics
//   cfg     | cfg_we, cfg_index, cfg_data   | in        | register write, no read-back
//
// An item that does not complete an intermediate sample only updates the integrator.
// An item that does runs the divider and then one multiply and one accumulate step
// per filter operation (10 in bypass, 11 with RC only, 16 with RC and LED), all
// on the one shared multiplier in each lane, then waits for the merging stage to take it;
// in_stall is high meanwhile.
// Reset is synchronous and clears all filter, integrator and counter state.
// A waiting result in the output register holds the lanes only when the next
// intermediate sample would produce another result.
`default_nettype none
module audio_resample_filter_chain
  import arfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic                    led_r;
  logic                    byp_r;
  logic [31:0]             step_r;
  logic signed [SUM_W-1:0] sum_l_r;
  logic signed [SUM_W-1:0] sum_r_r;
  logic [CNT_W-1:0]        count_r;

  logic signed [SUM_W-1:0] sum_l_nxt;
  logic signed [SUM_W-1:0] sum_r_nxt;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W-1:0]        rem_raw;
  logic [CNT_W-1:0]        rem;
  logic                    accept;
  logic                    trig;
  lane_status_t            st_l;
  lane_status_t            st_r;
  logic                    ack;

  always_comb begin
    accept    = in_valid && !in_stall;
    sum_l_nxt = sum_l_r + (SUM_W'(in_data.left_sample) <<< 16);
    sum_r_nxt = sum_r_r + (SUM_W'(in_data.right_sample) <<< 16);
    count_nxt = count_r + CNT_W'(65536);
    trig      = count_nxt >= CNT_W'(step_r);
    rem_raw   = count_nxt - CNT_W'(step_r);
    // A step lowered mid-run can leave a remainder of a whole step; it is dropped.
    rem       = (rem_raw >= CNT_W'(step_r)) ? '0 : rem_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r   <= 1'b0;
      byp_r   <= 1'b0;
      step_r  <= STEP_RESET;
      sum_l_r <= '0;
      sum_r_r <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LED:    led_r  <= cfg_data[0];
          REG_BYPASS: byp_r  <= cfg_data[0];
          REG_STEP:   step_r <= (cfg_data < STEP_MIN) ? STEP_MIN : cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (trig) begin
          count_r <= rem;
          sum_l_r <= SUM_W'(in_data.left_sample) * SUM_W'($signed({1'b0, rem}));
          sum_r_r <= SUM_W'(in_data.right_sample) * SUM_W'($signed({1'b0, rem}));
        end else begin
          count_r <= count_nxt;
          sum_l_r <= sum_l_nxt;
          sum_r_r <= sum_r_nxt;
        end
      end
    end
  end

  arfc_lane u_lane_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && trig),
    .sum    (sum_l_nxt),
    .n      (count_nxt),
    .byp    (byp_r),
    .led_on (led_r),
    .ack    (ack),
    .status (st_l)
  );

  arfc_lane u_lane_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && trig),
    .sum    (sum_r_nxt),
    .n      (count_nxt),
    .byp    (byp_r),
    .led_on (led_r),
    .ack    (ack),
    .status (st_r)
  );

  arfc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_l      (st_l),
    .st_r      (st_r),
    .out_stall (out_stall),
    .ack       (ack),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign in_stall = st_l.busy || st_r.busy;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    st_l.done == st_r.done)
    else $error("channel lanes finished in different cycles");

  a_trigger_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && trig) |=> in_stall)
    else $error("input not held off while an intermediate sample is processed");

  a_frame_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_total != 32'd0))
    else $error("result item presented with a zero frame count");

endmodule
`default_nettype wire
